// ===== hw/rtl/tama_pkg.sv =====
// shared types, constants and helpers for the three-axis moving average
package tama_pkg;

  localparam int unsigned WindowLengthDef = 30;
  localparam int unsigned SampleW         = 16;
  localparam int unsigned NumAxes         = 3;
  localparam int unsigned AxisX           = 0;
  localparam int unsigned AxisY           = 1;
  localparam int unsigned AxisZ           = 2;
  // register stages from input transfer to the output register
  localparam int unsigned PipeStages      = 5;

  typedef logic signed [SampleW-1:0] tama_sample_t;
  typedef logic [NumAxes-1:0][SampleW-1:0] tama_raw_t;

  typedef struct packed {
    logic [7:0] x_low;
    logic [7:0] x_high;
    logic [7:0] y_low;
    logic [7:0] y_high;
    logic [7:0] z_low;
    logic [7:0] z_high;
  } tama_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] raw_x;
    logic signed [SampleW-1:0] raw_y;
    logic signed [SampleW-1:0] raw_z;
    logic signed [SampleW-1:0] avg_x;
    logic signed [SampleW-1:0] avg_y;
    logic signed [SampleW-1:0] avg_z;
  } tama_out_t;

  // high byte on top, low byte with bit 0 cleared below
  function automatic tama_sample_t tama_assemble(logic [7:0] low, logic [7:0] high);
    return {high, low[7:1], 1'b0};
  endfunction

endpackage

// ===== hw/rtl/tama_ram.sv =====
// generic single-write, single-read ram with registered read data
module tama_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tama_acc.sv =====
// sample ring read-modify-write and running sums per axis
module tama_acc import tama_pkg::*; #(
  parameter int unsigned WindowLength = WindowLengthDef,
  localparam int unsigned SumW = SampleW + $clog2(WindowLength)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  tama_in_t                         in_data_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tama_raw_t                        out_raw_o,
  output logic [NumAxes-1:0][SumW-1:0]     out_sum_o
);

  localparam int unsigned SlotW  = (WindowLength > 1) ? $clog2(WindowLength) : 1;
  localparam int unsigned EntryW = NumAxes * SampleW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WindowLength - 1);

  logic                          en1, en2, in_xfer, st1_adv, fwd_hit;
  logic [SlotW-1:0]              slot_d, slot_q;
  logic [WindowLength-1:0]       vld_q;
  logic                          st1_v_q, st2_v_q;
  tama_raw_t                     new_raw, st1_raw_q, st1_fwd_data_q, old_raw, st2_raw_q;
  logic [SlotW-1:0]              st1_slot_q;
  logic                          st1_fwd_q, st1_ent_vld_q;
  logic [EntryW-1:0]             rd_data;
  logic [NumAxes-1:0][SumW-1:0]  sum_d, sum_q, st2_sum_q;

  // stage enables, a stage moves when the next one is free or moving
  assign en2        = !st2_v_q || out_ready_i;
  assign st1_adv    = st1_v_q && en2;
  assign en1        = !st1_v_q || en2;
  assign in_ready_o = en1;
  assign in_xfer    = in_valid_i && en1;

  // assemble the three samples
  assign new_raw[AxisX] = tama_assemble(in_data_i.x_low, in_data_i.x_high);
  assign new_raw[AxisY] = tama_assemble(in_data_i.y_low, in_data_i.y_high);
  assign new_raw[AxisZ] = tama_assemble(in_data_i.z_low, in_data_i.z_high);

  // write slot pointer with wrap
  assign slot_d = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);

  // the entry being written this cycle is the one being read
  assign fwd_hit = st1_adv && (st1_slot_q == slot_q);

  tama_ram #(
    .Width (EntryW),
    .Depth (WindowLength)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (st1_adv),
    .waddr_i (st1_slot_q),
    .wdata_i (st1_raw_q),
    .re_i    (in_xfer),
    .raddr_i (slot_q),
    .rdata_o (rd_data)
  );

  // oldest sample: forwarded write, ram data, or zero for an unwritten entry
  always_comb begin
    if (st1_fwd_q) begin
      old_raw = st1_fwd_data_q;
    end else if (st1_ent_vld_q) begin
      old_raw = rd_data;
    end else begin
      old_raw = '0;
    end
  end

  // running sums: drop the oldest sample, add the new one
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      sum_d[a] = sum_q[a] - SumW'($signed(old_raw[a])) + SumW'($signed(st1_raw_q[a]));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      vld_q   <= '0;
      sum_q   <= '0;
      st1_v_q <= 1'b0;
      st2_v_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        slot_q <= slot_d;
      end
      if (st1_adv) begin
        vld_q[st1_slot_q] <= 1'b1;
        sum_q             <= sum_d;
      end
      if (en1) begin
        st1_v_q <= in_valid_i;
      end
      if (en2) begin
        st2_v_q <= st1_v_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      st1_raw_q      <= new_raw;
      st1_slot_q     <= slot_q;
      st1_fwd_q      <= fwd_hit;
      st1_fwd_data_q <= st1_raw_q;
      st1_ent_vld_q  <= vld_q[slot_q] || fwd_hit;
    end
    if (st1_adv) begin
      st2_raw_q <= st1_raw_q;
      st2_sum_q <= sum_d;
    end
  end

  assign out_valid_o = st2_v_q;
  assign out_raw_o   = st2_raw_q;
  assign out_sum_o   = st2_sum_q;

endmodule

// ===== hw/rtl/tama_div.sv =====
// sum divided by the window length, truncated toward zero, via reciprocal multiply
module tama_div import tama_pkg::*; #(
  parameter int unsigned WindowLength = WindowLengthDef,
  localparam int unsigned SumW = SampleW + $clog2(WindowLength)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tama_raw_t                    in_raw_i,
  input  logic [NumAxes-1:0][SumW-1:0] in_sum_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tama_out_t                    out_data_o
);

  // exact for dividends below 2^SumW: q = (n * ceil(2^Shift / len)) >> Shift
  localparam int unsigned Shift = SumW + $clog2(WindowLength);
  localparam int unsigned MulW  = SumW + 1;
  localparam int unsigned ProdW = SumW + MulW;
  localparam int unsigned QuotW = SampleW + 1;
  localparam logic [MulW-1:0] Recip =
    MulW'(((64'd1 << Shift) + 64'(WindowLength) - 64'd1) / 64'(WindowLength));

  logic                            en3, en4, en_out;
  logic                            st3_v_q, st4_v_q, out_v_q;
  tama_raw_t                       st3_raw_q, st4_raw_q;
  logic [NumAxes-1:0][SumW-1:0]    mag_d, st3_mag_q;
  logic [NumAxes-1:0]              st3_neg_q, st4_neg_q;
  logic [NumAxes-1:0][ProdW-1:0]   st4_prod_q;
  logic [NumAxes-1:0][QuotW-1:0]   quot;
  logic [NumAxes-1:0][SampleW-1:0] avg_d;
  tama_out_t                       out_q;

  assign en_out     = !out_v_q || !out_stall_i;
  assign en4        = !st4_v_q || en_out;
  assign en3        = !st3_v_q || en4;
  assign in_ready_o = en3;

  // magnitude of each sum
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      mag_d[a] = in_sum_i[a][SumW-1] ? (SumW'(0) - in_sum_i[a]) : in_sum_i[a];
    end
  end

  // quotient from the product, sign restored
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      quot[a]  = st4_prod_q[a][Shift +: QuotW];
      avg_d[a] = st4_neg_q[a] ? SampleW'(QuotW'(0) - quot[a]) : SampleW'(quot[a]);
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st3_v_q <= 1'b0;
      st4_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en3) begin
        st3_v_q <= in_valid_i;
      end
      if (en4) begin
        st4_v_q <= st3_v_q;
      end
      if (en_out) begin
        out_v_q <= st4_v_q;
      end
    end
  end

  // magnitude, product and result registers
  always_ff @(posedge clk_i) begin
    if (en3 && in_valid_i) begin
      st3_raw_q <= in_raw_i;
      st3_mag_q <= mag_d;
      for (int a = 0; a < NumAxes; a++) begin
        st3_neg_q[a] <= in_sum_i[a][SumW-1];
      end
    end
    if (en4 && st3_v_q) begin
      st4_raw_q <= st3_raw_q;
      st4_neg_q <= st3_neg_q;
      for (int a = 0; a < NumAxes; a++) begin
        st4_prod_q[a] <= ProdW'(st3_mag_q[a]) * ProdW'(Recip);
      end
    end
    if (en_out && st4_v_q) begin
      out_q.raw_x <= st4_raw_q[AxisX];
      out_q.raw_y <= st4_raw_q[AxisY];
      out_q.raw_z <= st4_raw_q[AxisZ];
      out_q.avg_x <= avg_d[AxisX];
      out_q.avg_y <= avg_d[AxisY];
      out_q.avg_z <= avg_d[AxisZ];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/three_axis_moving_average_top.sv =====
// Three-axis moving average, top level.
// Each item passes five register stages after its input transfer (ring read, sum update,
// magnitude, reciprocal multiply, output register); one ring read and one write per item.
// Throughput: one item per cycle; input stalls only when the output register stays stalled
// and the five stages are full.
// Reset clears the pipeline, write slot, running sums and per-entry ring valid bits at once;
// no clearing pass is needed.
module three_axis_moving_average_top import tama_pkg::*; #(
  parameter int unsigned WindowLength = WindowLengthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tama_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tama_out_t out_data_o
);

  localparam int unsigned SumW = SampleW + $clog2(WindowLength);

  logic                         acc_ready, acc_valid, div_ready;
  tama_raw_t                    acc_raw;
  logic [NumAxes-1:0][SumW-1:0] acc_sum;

  // ring and running sums
  tama_acc #(
    .WindowLength (WindowLength)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (acc_ready),
    .out_valid_o (acc_valid),
    .out_ready_i (div_ready),
    .out_raw_o   (acc_raw),
    .out_sum_o   (acc_sum)
  );

  // division by the window length and output register
  tama_div #(
    .WindowLength (WindowLength)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (acc_valid),
    .in_ready_o  (div_ready),
    .in_raw_i    (acc_raw),
    .in_sum_i    (acc_sum),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !acc_ready;

endmodule

// ===== hw/rtl/tama_checker.sv =====
// port-level checker for the three-axis moving average, bound to the top level
module tama_checker import tama_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input tama_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input tama_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(PipeStages + 1);

  logic            in_xfer, out_xfer;
  logic [CntW-1:0] inflight_d, inflight_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // items accepted but not yet delivered
  always_comb begin
    inflight_d = inflight_q;
    if (in_xfer && !out_xfer) begin
      inflight_d = inflight_q + CntW'(1);
    end else if (out_xfer && !in_xfer) begin
      inflight_d = inflight_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // no result without an accepted item behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("result without accepted item");

  // never more items inside than pipeline stages
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(PipeStages))
    else $error("too many items in flight");

  // an empty output register never holds back the input
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // input payload is observed only through the transfer count
  logic unused_in;
  assign unused_in = ^in_data_i;

endmodule

bind three_axis_moving_average_top tama_checker u_tama_checker (.*);
